[sv/bf3_pkg.sv]
`default_nettype none
// ============================================================================
// bf3_pkg
// Shared constants and types for the 3x3 box (mean) filter.
// ============================================================================
package bf3_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    // Fixed field widths of the stream and configuration ports.
    localparam int PIXEL_IN_BITS     = 8;
    localparam int PIXEL_OUT_BITS    = 8;
    localparam int OUT_ROW_BITS      = 12;
    localparam int OUT_COL_BITS      = 10;
    localparam int FRAME_WIDTH_BITS  = 11;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam int BORDER_BITS       = 8;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 13;
    localparam int IN_TDATA_BITS     = 8;
    localparam int OUT_TDATA_BITS    = 32;

    // Frame geometry limits and reset values.
    localparam int MIN_DIM        = 3;
    localparam int MAX_HEIGHT     = 4096;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int RESET_BORDER   = 255;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BORDER_VALUE = 2'd2;

    // Frame settings that do not depend on the parameters.
    typedef struct packed {
        logic [FRAME_HEIGHT_BITS-1:0] height;
        logic [BORDER_BITS-1:0]       border;
    } cfg_t;

    // Output position of the beat held in the first stage.
    typedef struct packed {
        logic                    emit;
        logic                    last;
        logic [OUT_ROW_BITS-1:0] row;
    } pos_t;

    // Per-result information carried from the window stage to the output.
    typedef struct packed {
        logic                    border;
        logic                    last;
        logic [OUT_ROW_BITS-1:0] row;
    } meta_t;

endpackage
`default_nettype wire

[sv/bf3_ctrl.sv]
`default_nettype none
// ============================================================================
// bf3_ctrl
// Configuration registers, raster position counters and the first stage.
// ============================================================================
module bf3_ctrl #(
    parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = bf3_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [bf3_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  wire logic                                in_valid,
    input  wire logic [bf3_pkg::PIXEL_IN_BITS-1:0]   in_pixel,
    input  wire logic                                in_pad,
    input  wire logic                                adv1,
    output logic [$clog2(MAX_WIDTH)-1:0]             col,
    output logic [PIXEL_BITS-1:0]                    in_pix,
    output logic [$clog2(MAX_WIDTH+1)-1:0]           width,
    output bf3_pkg::cfg_t                            cfg,
    output logic                                     s1_valid,
    output bf3_pkg::pos_t                            s1_pos,
    output logic [$clog2(MAX_WIDTH)-1:0]             s1_col,
    output logic [PIXEL_BITS-1:0]                    s1_pix
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HB = bf3_pkg::FRAME_HEIGHT_BITS;
    localparam int RESET_W = (bf3_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                : bf3_pkg::RESET_WIDTH;

    logic [WW-1:0]   width_reg;
    logic [WW-1:0]   width_next;
    logic [HB-1:0]   height_reg;
    logic [HB-1:0]   height_next;
    logic [bf3_pkg::BORDER_BITS-1:0] border_reg;
    logic [HB-1:0]   row_cnt_reg;
    logic [HB-1:0]   row_cnt_next;
    logic [CW-1:0]   col_cnt_reg;
    logic [CW-1:0]   col_cnt_next;
    logic            s1_valid_reg;
    bf3_pkg::pos_t   s1_pos_reg;
    bf3_pkg::pos_t   s1_pos_next;
    logic [CW-1:0]   s1_col_reg;
    logic [CW-1:0]   s1_col_next;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [PIXEL_BITS-1:0] pix_value;
    logic [CW:0]     col_inc;
    logic [HB-1:0]   row_full;
    logic            accept;
    logic            wr_geom;
    logic [bf3_pkg::FRAME_WIDTH_BITS-1:0] wr_width;

    assign accept   = in_valid && adv1;
    assign wr_width = cfg_wdata[bf3_pkg::FRAME_WIDTH_BITS-1:0];
    assign wr_geom  = cfg_wr_en && ((cfg_index == bf3_pkg::REG_FRAME_WIDTH) ||
                                    (cfg_index == bf3_pkg::REG_FRAME_HEIGHT));

    // Out-of-range geometry is clamped once, when it is written.
    always_comb
    begin
        if (wr_width < bf3_pkg::FRAME_WIDTH_BITS'(bf3_pkg::MIN_DIM))
            width_next = WW'(bf3_pkg::MIN_DIM);
        else if (32'(wr_width) > MAX_WIDTH)
            width_next = WW'(MAX_WIDTH);
        else
            width_next = WW'(wr_width);

        if (cfg_wdata < HB'(bf3_pkg::MIN_DIM))
            height_next = HB'(bf3_pkg::MIN_DIM);
        else if (32'(cfg_wdata) > bf3_pkg::MAX_HEIGHT)
            height_next = HB'(bf3_pkg::MAX_HEIGHT);
        else
            height_next = cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(RESET_W);
            height_reg <= HB'(bf3_pkg::RESET_HEIGHT);
            border_reg <= bf3_pkg::BORDER_BITS'(bf3_pkg::RESET_BORDER);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bf3_pkg::REG_FRAME_WIDTH:  width_reg  <= width_next;
                bf3_pkg::REG_FRAME_HEIGHT: height_reg <= height_next;
                bf3_pkg::REG_BORDER_VALUE: border_reg <= cfg_wdata[bf3_pkg::BORDER_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    assign pix_value = in_pad ? '0 : PIXEL_BITS'(in_pixel);
    assign col_inc   = (CW+1)'(col_cnt_reg) + (CW+1)'(1);
    assign row_full  = (col_cnt_reg != '0) ? row_cnt_reg - HB'(1) : row_cnt_reg - HB'(2);

    // The output position trails the input position by one row plus one pixel.
    always_comb
    begin
        s1_pos_next.emit = (row_cnt_reg >= HB'(2)) ||
                           ((row_cnt_reg == HB'(1)) && (col_cnt_reg != '0));
        s1_pos_next.last = (row_cnt_reg == height_reg + HB'(1)) && (col_cnt_reg == '0);
        s1_pos_next.row  = row_full[bf3_pkg::OUT_ROW_BITS-1:0];
        s1_col_next      = (col_cnt_reg != '0) ? col_cnt_reg - CW'(1)
                                               : CW'(width_reg - WW'(1));

        if (s1_pos_next.last)
        begin
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (col_inc >= (CW+1)'(width_reg))
        begin
            row_cnt_next = row_cnt_reg + HB'(1);
            col_cnt_next = '0;
        end
        else
        begin
            row_cnt_next = row_cnt_reg;
            col_cnt_next = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_geom)
            begin
                row_cnt_reg <= '0;
                col_cnt_reg <= '0;
            end
            else if (accept)
            begin
                row_cnt_reg <= row_cnt_next;
                col_cnt_reg <= col_cnt_next;
            end
            if (adv1)
                s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= s1_pos_next;
            s1_col_reg <= s1_col_next;
            s1_pix_reg <= pix_value;
        end
    end

    assign col        = col_cnt_reg;
    assign in_pix     = pix_value;
    assign width      = width_reg;
    assign cfg.height = height_reg;
    assign cfg.border = border_reg;
    assign s1_valid   = s1_valid_reg;
    assign s1_pos     = s1_pos_reg;
    assign s1_col     = s1_col_reg;
    assign s1_pix     = s1_pix_reg;

endmodule
`default_nettype wire

[sv/bf3_line_store.sv]
`default_nettype none
// ============================================================================
// bf3_line_store
// Two row memories that hold the previous two image rows.
// ============================================================================
module bf3_line_store #(
    parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = bf3_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  wire logic [PIXEL_BITS-1:0]        pix,
    output logic [PIXEL_BITS-1:0]             top,
    output logic [PIXEL_BITS-1:0]             mid
);

    logic [PIXEL_BITS-1:0] store_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] store_b [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] top_reg;
    logic [PIXEL_BITS-1:0] mid_reg;

    // Read-before-write at one address: the previous row moves down one store
    // while the new pixel takes its place.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg       <= store_b[addr];
            mid_reg       <= store_a[addr];
            store_b[addr] <= store_a[addr];
            store_a[addr] <= pix;
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule
`default_nettype wire

[sv/bf3_window.sv]
`default_nettype none
// ============================================================================
// bf3_window
// 3x3 window shift, nine-pixel sum and border decision (second stage).
// ============================================================================
module bf3_window #(
    parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = bf3_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv2,
    input  wire logic                           s1_valid,
    input  wire bf3_pkg::pos_t                  s1_pos,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]   s1_col,
    input  wire logic [PIXEL_BITS-1:0]          s1_pix,
    input  wire logic [PIXEL_BITS-1:0]          top,
    input  wire logic [PIXEL_BITS-1:0]          mid,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0] width,
    input  wire bf3_pkg::cfg_t                  cfg,
    output logic                                s2_valid,
    output bf3_pkg::meta_t                      s2_meta,
    output logic [$clog2(MAX_WIDTH)-1:0]        s2_col,
    output logic [PIXEL_BITS+3:0]               s2_sum
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int SB = PIXEL_BITS + 4;
    localparam int HB = bf3_pkg::FRAME_HEIGHT_BITS;

    logic [PIXEL_BITS-1:0] win_reg  [9];
    logic [PIXEL_BITS-1:0] win_next [9];
    logic [SB-1:0]         sum_reg;
    logic [SB-1:0]         sum_next;
    logic                  s2_valid_reg;
    bf3_pkg::meta_t        meta_reg;
    bf3_pkg::meta_t        meta_next;
    logic [CW-1:0]         col_reg;
    logic                  shift;

    assign shift = adv2 && s1_valid;

    // Rows of the window are top, middle and current; the newest column is
    // on the right.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = s1_pix;

        sum_next = '0;
        for (int k = 0; k < 9; k++)
            sum_next = sum_next + SB'(win_next[k]);

        meta_next.border = (s1_pos.row == '0) ||
                           ({1'b0, s1_pos.row} >= cfg.height - HB'(1)) ||
                           (s1_col == '0) ||
                           (WW'(s1_col) >= width - WW'(1));
        meta_next.last   = s1_pos.last;
        meta_next.row    = s1_pos.row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else
        begin
            if (adv2)
                s2_valid_reg <= s1_valid && s1_pos.emit;
            if (shift)
                for (int k = 0; k < 9; k++)
                    win_reg[k] <= win_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sum_reg  <= sum_next;
            meta_reg <= meta_next;
            col_reg  <= s1_col;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_meta  = meta_reg;
    assign s2_col   = col_reg;
    assign s2_sum   = sum_reg;

endmodule
`default_nettype wire

[sv/bf3_divide.sv]
`default_nettype none
// ============================================================================
// bf3_divide
// Divide-by-nine, border selection and the output register.
// ============================================================================
module bf3_divide #(
    parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = bf3_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv3,
    input  wire logic                                s2_valid,
    input  wire bf3_pkg::meta_t                      s2_meta,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]        s2_col,
    input  wire logic [PIXEL_BITS+3:0]               s2_sum,
    input  wire bf3_pkg::cfg_t                       cfg,
    output logic                                     out_valid,
    output logic [bf3_pkg::PIXEL_OUT_BITS-1:0]       out_pixel,
    output logic [bf3_pkg::OUT_ROW_BITS-1:0]         out_row,
    output logic [bf3_pkg::OUT_COL_BITS-1:0]         out_col,
    output logic                                     out_last
);

    localparam int SB = PIXEL_BITS + 4;
    localparam int QB = SB - 3;
    localparam logic [QB-1:0] RECIP = QB'((2 ** SB) / 9);

    logic [SB+QB-1:0] product;
    logic [QB-1:0]    quot_est;
    logic [SB-1:0]    remainder;
    logic [QB-1:0]    quot;
    logic [bf3_pkg::PIXEL_OUT_BITS-1:0] pixel_next;

    logic                               out_valid_reg;
    logic [bf3_pkg::PIXEL_OUT_BITS-1:0] pixel_reg;
    logic [bf3_pkg::OUT_ROW_BITS-1:0]   row_reg;
    logic [bf3_pkg::OUT_COL_BITS-1:0]   col_reg;
    logic                               last_reg;

    // The reciprocal rounds down, so the estimate is at most one below the
    // true quotient; one compare against the remainder fixes it.
    always_comb
    begin
        product   = (SB+QB)'(s2_sum) * (SB+QB)'(RECIP);
        quot_est  = product[SB+QB-1:SB];
        remainder = s2_sum - ((SB'(quot_est) << 3) + SB'(quot_est));
        quot      = (remainder >= SB'(9)) ? quot_est + QB'(1) : quot_est;
        pixel_next = s2_meta.border ? cfg.border
                                    : bf3_pkg::PIXEL_OUT_BITS'(quot[PIXEL_BITS-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv3)
            out_valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid)
        begin
            pixel_reg <= pixel_next;
            row_reg   <= s2_meta.row;
            col_reg   <= bf3_pkg::OUT_COL_BITS'(s2_col);
            last_reg  <= s2_meta.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = pixel_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

[sv/box_filter_3x3_mean.sv]
`default_nettype none
// ============================================================================
// box_filter_3x3_mean
// Streaming 3x3 mean filter for grey pixels in raster order.
// ============================================================================
// Usage: pixels enter on s_axis one beat each, tdata holding the grey level
// and tuser the pad flag. Each frame is frame_width*frame_height pixels
// followed by frame_width+1 pad beats that flush the last results. Results
// leave on m_axis: one beat per raster position once the input is one row
// plus one pixel ahead, with tlast on the last pixel of the frame. Interior
// pixels carry floor(sum of the 3x3 neighborhood / 9); border pixels carry
// border_value.
// Throughput is one beat per cycle while the receiver does not stall. The line
// store read is registered at the edge that accepts the beat completing its
// window, then the window sum in the second stage and the divide by nine in
// the output register, where the result becomes valid on m_axis.
// When the receiver stalls, the three stages fill their empty slots and
// s_axis_tready falls only when all of them hold data.
// Reset sets width 640, height 480, border 255, clears the position counters
// and the pipeline; the line stores are not cleared. Writing width or height
// restarts the frame position at row zero, column zero.
// ============================================================================
module box_filter_3x3_mean #(
    parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = bf3_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [bf3_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [bf3_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,   // [7:0] pixel_in
    input  wire logic                                s_axis_tuser,   // [0] pad
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [bf3_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata,   // [7:0] pixel_out,
                                                                     // [19:8] out_row,
                                                                     // [29:20] out_col
    output logic                                     m_axis_tlast    // frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic                  adv1;
    logic                  adv2;
    logic                  adv3;
    logic [CW-1:0]         col;
    logic [PIXEL_BITS-1:0] in_pix;
    logic [WW-1:0]         width;
    bf3_pkg::cfg_t         cfg;
    logic                  s1_valid;
    bf3_pkg::pos_t         s1_pos;
    logic [CW-1:0]         s1_col;
    logic [PIXEL_BITS-1:0] s1_pix;
    logic [PIXEL_BITS-1:0] top;
    logic [PIXEL_BITS-1:0] mid;
    logic                  s2_valid;
    bf3_pkg::meta_t        s2_meta;
    logic [CW-1:0]         s2_col;
    logic [PIXEL_BITS+3:0] s2_sum;
    logic                  out_valid;
    logic [bf3_pkg::PIXEL_OUT_BITS-1:0] out_pixel;
    logic [bf3_pkg::OUT_ROW_BITS-1:0]   out_row;
    logic [bf3_pkg::OUT_COL_BITS-1:0]   out_col;
    logic                               out_last;

    // A stage moves forward when it is empty or the stage after it moves.
    assign adv3 = !out_valid || m_axis_tready;
    assign adv2 = !s2_valid || adv3;
    assign adv1 = !s1_valid || adv2;

    bf3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_pixel  (s_axis_tdata),
        .in_pad    (s_axis_tuser),
        .adv1      (adv1),
        .col       (col),
        .in_pix    (in_pix),
        .width     (width),
        .cfg       (cfg),
        .s1_valid  (s1_valid),
        .s1_pos    (s1_pos),
        .s1_col    (s1_col),
        .s1_pix    (s1_pix)
    );

    bf3_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_store (
        .clk  (clk),
        .en   (s_axis_tvalid && adv1),
        .addr (col),
        .pix  (in_pix),
        .top  (top),
        .mid  (mid)
    );

    bf3_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv2     (adv2),
        .s1_valid (s1_valid),
        .s1_pos   (s1_pos),
        .s1_col   (s1_col),
        .s1_pix   (s1_pix),
        .top      (top),
        .mid      (mid),
        .width    (width),
        .cfg      (cfg),
        .s2_valid (s2_valid),
        .s2_meta  (s2_meta),
        .s2_col   (s2_col),
        .s2_sum   (s2_sum)
    );

    bf3_divide #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv3      (adv3),
        .s2_valid  (s2_valid),
        .s2_meta   (s2_meta),
        .s2_col    (s2_col),
        .s2_sum    (s2_sum),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (out_last)
    );

    assign s_axis_tready = adv1;
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {2'b00, out_col, out_row, out_pixel};
    assign m_axis_tlast  = out_last;

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the streaming 3x3 mean filter.
// ============================================================================
// Whole frames of grey pixels go in, each followed by its flush beats. A
// behavioral model of the line stores, the window and the raster counters
// predicts every output pixel with its coordinates and end-of-frame flag.
// Results are compared in order against that prediction. The stimulus covers
// short hand-built frames, many small random frames (including aborted
// frames, odd flush lengths and a pause in mid-frame) and then the top rows
// of frames at the largest width and height. The sender works in bursts and
// the receiver stalls on a pattern that changes from time to time.
// ============================================================================
module testbench;

    localparam int PIX_MAX   = 255;
    localparam int LINE_LEN  = bf3_pkg::DEF_MAX_WIDTH;
    localparam int SETTLE    = 8;
    localparam int RAND_GOAL = 450;
    localparam int MAX_PRINT = 100;

    typedef struct {
        logic [bf3_pkg::PIXEL_IN_BITS-1:0] value;
        logic                              pad;
    } grey_beat_t;

    typedef struct {
        logic [bf3_pkg::PIXEL_OUT_BITS-1:0] grey;
        logic [bf3_pkg::OUT_ROW_BITS-1:0]   row;
        logic [bf3_pkg::OUT_COL_BITS-1:0]   col;
        logic                               last;
    } out_pixel_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_WHITE,
        FILL_BLACK,
        FILL_EXTREMES,
        FILL_BRIGHT
    } fill_style_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                  cfg_wr_en     = 1'b0;
    logic [bf3_pkg::CFG_INDEX_BITS-1:0]    cfg_index     = bf3_pkg::REG_FRAME_WIDTH;
    logic [bf3_pkg::CFG_DATA_BITS-1:0]     cfg_wdata     = '0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [bf3_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata  = '0;
    logic                                  s_axis_tuser  = 1'b0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [bf3_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata;
    logic                                  m_axis_tlast;

    box_filter_3x3_mean DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Filter model: settings, line stores, window and raster position.
    // ------------------------------------------------------------------
    int unsigned              set_width  = bf3_pkg::RESET_WIDTH;
    int unsigned              set_height = bf3_pkg::RESET_HEIGHT;
    int unsigned              set_border = bf3_pkg::RESET_BORDER;
    logic [7:0]               row_above1 [LINE_LEN];
    logic [7:0]               row_above2 [LINE_LEN];
    int unsigned              window [9];
    int unsigned              row_pos    = 0;
    int unsigned              col_pos    = 0;
    out_pixel_t               pixel_expect_q [$];

    initial
    begin
        for (int i = 0; i < LINE_LEN; i++)
        begin
            row_above1[i] = '0;
            row_above2[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            window[i] = 0;
    end

    function automatic int unsigned used_width();
        if (set_width < bf3_pkg::MIN_DIM)
            return bf3_pkg::MIN_DIM;
        if (set_width > LINE_LEN)
            return LINE_LEN;
        return set_width;
    endfunction

    function automatic int unsigned used_height();
        if (set_height < bf3_pkg::MIN_DIM)
            return bf3_pkg::MIN_DIM;
        if (set_height > bf3_pkg::MAX_HEIGHT)
            return bf3_pkg::MAX_HEIGHT;
        return set_height;
    endfunction

    function automatic void set_register(input logic [bf3_pkg::CFG_INDEX_BITS-1:0] idx,
                                         input int unsigned value);
        case (idx)
            bf3_pkg::REG_FRAME_WIDTH:
            begin
                set_width = value & 'h7FF;
                row_pos   = 0;
                col_pos   = 0;
            end
            bf3_pkg::REG_FRAME_HEIGHT:
            begin
                set_height = value & 'h1FFF;
                row_pos    = 0;
                col_pos    = 0;
            end
            bf3_pkg::REG_BORDER_VALUE:
                set_border = value & 'hFF;
            default:
                ;
        endcase
    endfunction

    // Consume one beat and queue the output pixel it completes, if any.
    function automatic void box_mean_step(input logic [7:0] pix, input logic pad);
        int unsigned w;
        int unsigned h;
        int unsigned ir;
        int unsigned ic;
        int unsigned v;
        int unsigned top;
        int unsigned mid;
        int unsigned orow;
        int unsigned ocol;
        int unsigned total;
        bit          emit;
        bit          last;
        out_pixel_t  res;

        w  = used_width();
        h  = used_height();
        ir = row_pos;
        ic = col_pos;
        v  = pad ? 0 : pix;

        top            = row_above2[ic];
        mid            = row_above1[ic];
        row_above2[ic] = mid[7:0];
        row_above1[ic] = v[7:0];
        for (int k = 0; k < 3; k++)
        begin
            window[k * 3]     = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = v;

        emit = (ir >= 2) || (ir == 1 && ic >= 1);
        last = (ir == h + 1) && (ic == 0);

        if (last)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        else
        begin
            ic++;
            if (ic >= w)
            begin
                ic = 0;
                ir++;
            end
            row_pos = ir & 'h1FFF;
            col_pos = ic & 'h3FF;
            // Step back to the position that was just consumed.
            if (ic == 0)
            begin
                ir--;
                ic = w - 1;
            end
            else
                ic--;
        end
        if (!emit)
            return;

        if (last)
        begin
            orow = h - 1;
            ocol = w - 1;
        end
        else if (ic >= 1)
        begin
            orow = ir - 1;
            ocol = ic - 1;
        end
        else
        begin
            orow = ir - 2;
            ocol = w - 1;
        end

        if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1)
            res.grey = set_border[7:0];
        else
        begin
            total = 0;
            for (int k = 0; k < 9; k++)
                total += window[k];
            res.grey = bf3_pkg::PIXEL_OUT_BITS'(total / 9);
        end
        res.row  = orow[bf3_pkg::OUT_ROW_BITS-1:0];
        res.col  = ocol[bf3_pkg::OUT_COL_BITS-1:0];
        res.last = last;
        pixel_expect_q.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting.
    // ------------------------------------------------------------------
    int unsigned fail_count = 0;

    task automatic report_error(input string msg);
        // Printing stops after a while; counting does not.
        if (fail_count < MAX_PRINT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Pixel driver: bursts of random length with random gaps.
    // ------------------------------------------------------------------
    grey_beat_t  pixel_q [$];
    grey_beat_t  next_beat;
    int unsigned beats_sent  = 0;
    int unsigned beats_taken = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    bit          steady      = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                box_mean_step(s_axis_tdata[bf3_pkg::PIXEL_IN_BITS-1:0], s_axis_tuser);
                beats_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    next_beat     = pixel_q.pop_front();
                    s_axis_tdata  <= next_beat.value;
                    s_axis_tuser  <= next_beat.pad;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left != 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 31);
                        gap_left   = steady ? 0 : $urandom_range(0, 6);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with its own stall pattern.
    // ------------------------------------------------------------------
    out_pixel_t  want;
    logic [15:0] ready_pattern = '1;
    int unsigned pattern_left  = 0;
    int unsigned pattern_bit   = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_expect_q.size() == 0)
                    report_error($sformatf("result beat with nothing expected, tdata %h",
                                           m_axis_tdata));
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.grey)
                        report_error($sformatf("pixel_out %0d, expected %0d at (%0d,%0d)",
                                               m_axis_tdata[7:0], want.grey,
                                               want.row, want.col));
                    if (m_axis_tdata[19:8] !== want.row)
                        report_error($sformatf("out_row %0d, expected %0d",
                                               m_axis_tdata[19:8], want.row));
                    if (m_axis_tdata[29:20] !== want.col)
                        report_error($sformatf("out_col %0d, expected %0d",
                                               m_axis_tdata[29:20], want.col));
                    if (m_axis_tlast !== want.last)
                        report_error($sformatf("frame_last %b, expected %b at (%0d,%0d)",
                                               m_axis_tlast, want.last,
                                               want.row, want.col));
                end
            end
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(16, 96);
                if ($urandom_range(0, 3) == 0)
                    ready_pattern = '1;
                else
                    ready_pattern = 16'($urandom) | 16'h0001;
            end
            pattern_left--;
            pattern_bit = (pattern_bit + 1) % 16;
            m_axis_tready <= ready_pattern[pattern_bit];
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_beat(input int unsigned value, input bit pad);
        grey_beat_t b;
        b.value = value[bf3_pkg::PIXEL_IN_BITS-1:0];
        b.pad   = pad;
        pixel_q.push_back(b);
        beats_sent++;
    endtask

    // Wait until every beat is taken and every result has come back.
    task automatic wait_drained(input int unsigned settle);
        while (beats_taken != beats_sent || pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bf3_pkg::CFG_INDEX_BITS-1:0] idx,
                             input int unsigned value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[bf3_pkg::CFG_DATA_BITS-1:0];
        set_register(idx, value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int unsigned pick_grey(input fill_style_t style);
        case (style)
            FILL_WHITE:    return PIX_MAX;
            FILL_BLACK:    return 0;
            FILL_EXTREMES: return $urandom_range(0, 1) ? PIX_MAX : 0;
            FILL_BRIGHT:   return $urandom_range(240, PIX_MAX);
            default:       return $urandom_range(0, PIX_MAX);
        endcase
    endfunction

    // Queue pixel beats (a pad now and then) and the flush beats after them.
    // The sender holds off at beat hold_at until the block has caught up.
    task automatic queue_frame(input int unsigned pixels, input int unsigned flush,
                               input fill_style_t style, input int hold_at);
        for (int i = 0; i < pixels; i++)
        begin
            if (i == hold_at)
                wait_drained(0);
            push_beat(pick_grey(style), $urandom_range(0, 19) == 0);
        end
        // Flush beats are mostly pads; real pixels here must never show up.
        for (int i = 0; i < flush; i++)
            push_beat($urandom_range(0, PIX_MAX), $urandom_range(0, 3) != 0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned pixels;
        int unsigned flush;
        int unsigned start_count;
        int          hold_at;
        int unsigned kind;
        bit          need_restart;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest frame, black border, a pad in the middle counting as zero
        // and real pixels mixed into the flush.
        write_reg(bf3_pkg::REG_FRAME_WIDTH, bf3_pkg::MIN_DIM);
        write_reg(bf3_pkg::REG_FRAME_HEIGHT, bf3_pkg::MIN_DIM);
        write_reg(bf3_pkg::REG_BORDER_VALUE, 0);
        for (int i = 0; i < 9; i++)
            push_beat((i == 0) ? 0 : PIX_MAX, i == 4);
        push_beat(0, 1'b1);
        push_beat('hA5, 1'b0);
        push_beat(0, 1'b1);
        push_beat('h5A, 1'b0);
        wait_drained(SETTLE);

        // Width and height below the minimum are taken as three.
        write_reg(bf3_pkg::REG_FRAME_WIDTH, 0);
        write_reg(bf3_pkg::REG_FRAME_HEIGHT, 1);
        write_reg(bf3_pkg::REG_BORDER_VALUE, PIX_MAX);
        for (int i = 0; i < 9; i++)
            push_beat(PIX_MAX, 1'b0);
        for (int i = 0; i < 4; i++)
            push_beat(0, 1'b1);

        // Random frames, mostly well formed.
        start_count  = beats_sent;
        need_restart = 1'b1;
        w            = bf3_pkg::MIN_DIM;
        h            = bf3_pkg::MIN_DIM;
        while (beats_sent - start_count < RAND_GOAL)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if (need_restart || $urandom_range(0, 2) != 0)
            begin
                wait_drained(SETTLE);
                if ($urandom_range(0, 9) == 0)
                    write_reg(bf3_pkg::REG_FRAME_WIDTH, $urandom_range(0, 2));
                else if ($urandom_range(0, 7) == 0)
                    write_reg(bf3_pkg::REG_FRAME_WIDTH, $urandom_range(11, 64));
                else
                    write_reg(bf3_pkg::REG_FRAME_WIDTH, $urandom_range(3, 10));
                write_reg(bf3_pkg::REG_FRAME_HEIGHT, $urandom_range(0, 7));
                if ($urandom_range(0, 1) != 0)
                    write_reg(bf3_pkg::REG_BORDER_VALUE, $urandom_range(0, PIX_MAX));
                w            = used_width();
                h            = used_height();
                need_restart = 1'b0;
            end
            pixels  = w * h;
            flush   = w + 1;
            hold_at = -1;
            kind    = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // Aborted frame: the next settings restart the position.
                pixels       = $urandom_range(1, w * h - 1);
                flush        = 0;
                need_restart = 1'b1;
            end
            else if (kind == 1)
            begin
                // Wrong flush length leaves the raster position shifted.
                if ($urandom_range(0, 1) != 0)
                    flush = flush - $urandom_range(1, w);
                else
                    flush = flush + $urandom_range(1, 3);
                need_restart = 1'($urandom_range(0, 1));
            end
            else if (kind == 2)
                hold_at = $urandom_range(1, w * h - 1);
            queue_frame(pixels, flush, fill_style_t'($urandom_range(0, 4)), hold_at);
        end

        // Largest width (clamped from the top of the register) with a pause;
        // the first two rows are enough to place the first results.
        wait_drained(SETTLE);
        steady = 1'b0;
        write_reg(bf3_pkg::REG_FRAME_WIDTH, 'h7FF);
        write_reg(bf3_pkg::REG_FRAME_HEIGHT, 2);
        write_reg(bf3_pkg::REG_BORDER_VALUE, PIX_MAX);
        w = used_width();
        h = used_height();
        queue_frame(w + 76, 0, FILL_RANDOM, 600);

        // Largest height (clamped from the top of the register); only the
        // top rows are sent.
        wait_drained(SETTLE);
        write_reg(bf3_pkg::REG_FRAME_WIDTH, bf3_pkg::MIN_DIM);
        write_reg(bf3_pkg::REG_FRAME_HEIGHT, 'h1FFF);
        write_reg(bf3_pkg::REG_BORDER_VALUE, 0);
        w = used_width();
        h = used_height();
        queue_frame(w * 20, 0, FILL_EXTREMES, -1);

        wait_drained(20);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
